### rtl/cfs_pkg.sv
// ============================================================================
// cfs_pkg: shared types and constants of the call-frame stack
// Command and status codes, field widths and the controller state type.
// ============================================================================
package cfs_pkg;

   // Field widths fixed by the channel payload.
   localparam int WORD_BITS = 32;
   localparam int CMD_BITS  = 4;
   localparam int SLOT_BITS = 4;
   localparam int STAT_BITS = 2;

   // Largest argument or local count a frame may hold.
   localparam int MAX_SLOTS = 15;

   // Return address and base pointer words kept in every frame.
   localparam int LINK_WORDS = 2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_CALL      = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_GET_LOCAL = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_SET_LOCAL = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_GET_ARG   = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_SET_ARG   = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_GET_BP    = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_GET_RA    = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_RETURN    = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_CURRENT   = 4'd8;

   // Status codes.
   localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_NO_FRAME  = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CALL_BP,
      S_READ,
      S_POP,
      S_EMIT
   } state_type;

endpackage

### rtl/cfs_req_if.sv
// ============================================================================
// cfs_req_if: command channel of the call-frame stack
// Valid/ready channel carrying one command beat.
// ============================================================================
interface cfs_req_if;
   import cfs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CMD_BITS-1:0]         command;
   logic [SLOT_BITS-1:0]        arg_count;
   logic [SLOT_BITS-1:0]        local_count;
   logic signed [WORD_BITS-1:0] ret_addr;
   logic signed [WORD_BITS-1:0] base_ptr;
   logic [SLOT_BITS-1:0]        slot_index;
   logic signed [WORD_BITS-1:0] value;

   modport source (
      output valid, command, arg_count, local_count, ret_addr, base_ptr,
             slot_index, value,
      input  ready
   );

   modport sink (
      input  valid, command, arg_count, local_count, ret_addr, base_ptr,
             slot_index, value,
      output ready
   );

endinterface

### rtl/cfs_rsp_if.sv
// ============================================================================
// cfs_rsp_if: response channel of the call-frame stack
// Valid/ready channel carrying one response beat per command.
// ============================================================================
interface cfs_rsp_if;
   import cfs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] read_value;
   logic [SLOT_BITS-1:0]        cur_arg_count;
   logic [SLOT_BITS-1:0]        cur_local_count;
   logic [STAT_BITS-1:0]        status;

   modport source (
      output valid, read_value, cur_arg_count, cur_local_count, status,
      input  ready
   );

   modport sink (
      input  valid, read_value, cur_arg_count, cur_local_count, status,
      output ready
   );

endinterface

### rtl/cfs_ram.sv
// ============================================================================
// cfs_ram: generic single-port synchronous RAM
// One read or write per cycle; read data is registered.
// ============================================================================
module cfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read of the same address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/call_frame_stack.sv
// ============================================================================
// call_frame_stack: hardware call-frame stack over one word memory
// Frame words live in a word memory, frame records in a frame memory.
// ============================================================================
// Commands arrive on req_ch and each produces exactly one response beat on
// rsp_ch. The word memory (STACK_WORDS words) holds arguments, return
// address, base pointer and locals of every frame; the frame memory
// (MAX_FRAMES records) holds each frame's argument count, local count and
// base, and the top frame's record is also kept in registers. A call writes
// the return address in S_IDLE, then the base pointer in S_CALL_BP, through
// the single word memory port. Get commands pass through S_READ for the
// registered memory read, and a return that uncovers an older frame passes
// through S_POP to read that frame's record back. Set, unused codes,
// current_frame, returns to an empty stack and all error cases finish in
// S_IDLE. One command is worked on at a time; a finished response waits in
// the output register while the next command is taken, and a second response
// held up by a stalled rsp_ch delays acceptance further. Memories are not
// cleared after reset; the user must set a slot before reading it (unchecked).
module call_frame_stack #(
   parameter int STACK_WORDS = 1024,
   parameter int MAX_FRAMES  = 64
) (
   input  logic      clock,
   input  logic      reset,
   cfs_req_if.sink   req_ch,
   cfs_rsp_if.source rsp_ch
);
   import cfs_pkg::*;

   localparam int AW   = $clog2(STACK_WORDS);
   localparam int TOPW = $clog2(STACK_WORDS + 1);
   localparam int SUMW = TOPW + 1;
   localparam int FW   = $clog2(MAX_FRAMES);
   localparam int DW   = $clog2(MAX_FRAMES + 1);
   localparam int FRW  = 2 * SLOT_BITS + AW;

   // Controller and stack pointers.
   state_type             state_ff, state_in;
   logic [TOPW-1:0]       word_top_ff, word_top_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [SLOT_BITS-1:0]  top_ac_ff, top_ac_in;
   logic [SLOT_BITS-1:0]  top_lc_ff, top_lc_in;
   logic [AW-1:0]         top_base_ff, top_base_in;
   logic [WORD_BITS-1:0]  bp_ff;

   // Held response while the output register is occupied.
   logic [WORD_BITS-1:0]  held_value_ff;
   logic [STAT_BITS-1:0]  held_status_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic [WORD_BITS-1:0]  rsp_value_ff;
   logic [SLOT_BITS-1:0]  rsp_ac_ff;
   logic [SLOT_BITS-1:0]  rsp_lc_ff;
   logic [STAT_BITS-1:0]  rsp_status_ff;

   // Memory ports.
   logic                  word_we;
   logic [AW-1:0]         word_addr;
   logic [WORD_BITS-1:0]  word_wdata;
   logic [WORD_BITS-1:0]  word_rdata;
   logic                  frame_we;
   logic [FW-1:0]         frame_addr;
   logic [FRW-1:0]        frame_wdata;
   logic [FRW-1:0]        frame_rdata;

   // Decode of the incoming beat.
   logic                  req_fire;
   logic                  rsp_free;
   logic                  has_frame;
   logic [5:0]            need;
   logic [SUMW-1:0]       call_end;
   logic [STAT_BITS-1:0]  st_now;
   logic                  go_call;
   logic                  go_read;
   logic                  go_set;
   logic                  go_ret;
   logic                  go_pop;
   logic [AW-1:0]         local_addr;
   logic [AW-1:0]         arg_addr;
   logic [AW-1:0]         ra_addr;
   logic [AW-1:0]         access_addr;

   // Finishing a command.
   logic                  finishing;
   logic [WORD_BITS-1:0]  fin_value;
   logic [STAT_BITS-1:0]  fin_status;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Word and frame record memories.
   cfs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STACK_WORDS)
   ) u_word_ram (
      .clock (clock),
      .we    (word_we),
      .addr  (word_addr),
      .wdata (word_wdata),
      .rdata (word_rdata)
   );

   cfs_ram #(
      .WIDTH (FRW),
      .DEPTH (MAX_FRAMES)
   ) u_frame_ram (
      .clock (clock),
      .we    (frame_we),
      .addr  (frame_addr),
      .wdata (frame_wdata),
      .rdata (frame_rdata)
   );

   // Command decode: status and the word address the command touches.
   always_comb begin
      has_frame  = (depth_ff != '0);
      need       = 6'(req_ch.arg_count) + 6'(req_ch.local_count) + 6'(LINK_WORDS);
      call_end   = SUMW'(word_top_ff) + SUMW'(need);
      local_addr = top_base_ff + AW'(top_ac_ff) + AW'(LINK_WORDS)
                   + AW'(req_ch.slot_index);
      arg_addr   = top_base_ff + AW'(top_ac_ff) - AW'(1) - AW'(req_ch.slot_index);
      ra_addr    = top_base_ff + AW'(top_ac_ff);
      st_now     = STAT_OK;
      access_addr = ra_addr;

      case (req_ch.command)
         CMD_CALL: begin
            if (32'(req_ch.arg_count) > MAX_SLOTS ||
                32'(req_ch.local_count) > MAX_SLOTS) begin
               st_now = STAT_BAD_INDEX;
            end else if (32'(depth_ff) >= MAX_FRAMES ||
                         32'(call_end) > STACK_WORDS) begin
               st_now = STAT_FULL;
            end
         end
         CMD_GET_LOCAL, CMD_SET_LOCAL: begin
            access_addr = local_addr;
            if (!has_frame) begin
               st_now = STAT_NO_FRAME;
            end else if (req_ch.slot_index >= top_lc_ff) begin
               st_now = STAT_BAD_INDEX;
            end
         end
         CMD_GET_ARG, CMD_SET_ARG: begin
            access_addr = arg_addr;
            if (!has_frame) begin
               st_now = STAT_NO_FRAME;
            end else if (req_ch.slot_index >= top_ac_ff) begin
               st_now = STAT_BAD_INDEX;
            end
         end
         CMD_GET_BP: begin
            access_addr = ra_addr + AW'(1);
            if (!has_frame) begin
               st_now = STAT_NO_FRAME;
            end
         end
         CMD_GET_RA, CMD_RETURN, CMD_CURRENT: begin
            if (!has_frame) begin
               st_now = STAT_NO_FRAME;
            end
         end
         default: begin
            st_now = STAT_OK;
         end
      endcase

      go_call = req_fire && (st_now == STAT_OK) && (req_ch.command == CMD_CALL);
      go_read = req_fire && (st_now == STAT_OK) &&
                (req_ch.command == CMD_GET_LOCAL || req_ch.command == CMD_GET_ARG ||
                 req_ch.command == CMD_GET_BP    || req_ch.command == CMD_GET_RA);
      go_set  = req_fire && (st_now == STAT_OK) &&
                (req_ch.command == CMD_SET_LOCAL || req_ch.command == CMD_SET_ARG);
      go_ret  = req_fire && (st_now == STAT_OK) && (req_ch.command == CMD_RETURN);
      go_pop  = go_ret && (depth_ff > DW'(1));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (go_call) begin
               state_in = S_CALL_BP;
            end else if (go_read) begin
               state_in = S_READ;
            end else if (go_pop) begin
               state_in = S_POP;
            end else if (req_fire && !rsp_free) begin
               state_in = S_EMIT;
            end
         end
         S_CALL_BP, S_READ, S_POP, S_EMIT: begin
            state_in = rsp_free ? S_IDLE : S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs of the controller: memory accesses and the finished response.
   always_comb begin
      word_we     = 1'b0;
      word_addr   = access_addr;
      word_wdata  = req_ch.value;
      frame_we    = 1'b0;
      frame_addr  = FW'(depth_ff - DW'(2));
      frame_wdata = {req_ch.arg_count, req_ch.local_count, AW'(word_top_ff)};
      finishing   = 1'b0;
      fin_value   = '0;
      fin_status  = STAT_OK;

      case (state_ff)
         S_IDLE: begin
            finishing  = req_fire && !go_call && !go_read && !go_pop;
            fin_status = st_now;
            if (go_call) begin
               // Return address first; base pointer goes in next cycle.
               word_we    = 1'b1;
               word_addr  = AW'(word_top_ff) + AW'(req_ch.arg_count);
               word_wdata = req_ch.ret_addr;
               frame_we   = 1'b1;
               frame_addr = FW'(depth_ff);
            end else if (go_set) begin
               word_we = 1'b1;
            end
         end
         S_CALL_BP: begin
            word_we    = 1'b1;
            word_addr  = top_base_ff + AW'(top_ac_ff) + AW'(1);
            word_wdata = bp_ff;
            finishing  = 1'b1;
         end
         S_READ: begin
            finishing = 1'b1;
            fin_value = word_rdata;
         end
         S_POP: begin
            finishing = 1'b1;
         end
         S_EMIT: begin
            finishing  = 1'b1;
            fin_value  = held_value_ff;
            fin_status = held_status_ff;
         end
         default: begin
            finishing = 1'b0;
         end
      endcase
   end

   // Stack pointer and top frame updates.
   always_comb begin
      word_top_in = word_top_ff;
      depth_in    = depth_ff;
      top_ac_in   = top_ac_ff;
      top_lc_in   = top_lc_ff;
      top_base_in = top_base_ff;

      if (go_call) begin
         word_top_in = TOPW'(call_end);
         depth_in    = depth_ff + DW'(1);
         top_ac_in   = req_ch.arg_count;
         top_lc_in   = req_ch.local_count;
         top_base_in = AW'(word_top_ff);
      end else if (go_ret) begin
         word_top_in = TOPW'(top_base_ff);
         depth_in    = depth_ff - DW'(1);
         if (!go_pop) begin
            // Last frame dropped: counts read as zero.
            top_ac_in   = '0;
            top_lc_in   = '0;
            top_base_in = '0;
         end
      end else if (state_ff == S_POP) begin
         top_ac_in   = frame_rdata[FRW-1 -: SLOT_BITS];
         top_lc_in   = frame_rdata[AW +: SLOT_BITS];
         top_base_in = frame_rdata[AW-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_top_ff  <= '0;
         depth_ff     <= '0;
         top_ac_ff    <= '0;
         top_lc_ff    <= '0;
         top_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         word_top_ff <= word_top_in;
         depth_ff    <= depth_in;
         top_ac_ff   <= top_ac_in;
         top_lc_ff   <= top_lc_in;
         top_base_ff <= top_base_in;
         if (finishing && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (go_call) begin
         bp_ff <= req_ch.base_ptr;
      end
      if (finishing && !rsp_free) begin
         held_value_ff  <= fin_value;
         held_status_ff <= fin_status;
      end
      if (finishing && rsp_free) begin
         rsp_value_ff  <= fin_value;
         rsp_ac_ff     <= top_ac_in;
         rsp_lc_ff     <= top_lc_in;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_value      = rsp_value_ff;
   assign rsp_ch.cur_arg_count   = rsp_ac_ff;
   assign rsp_ch.cur_local_count = rsp_lc_ff;
   assign rsp_ch.status          = rsp_status_ff;

endmodule

### dv/call_frame_stack_test.sv
// ============================================================================
// call_frame_stack_test: self-checking bench for the call-frame stack
// Drives command beats with random gaps and response stalls. A behavioral
// frame stack inside the bench predicts every response, and each response
// beat is checked field by field against the oldest prediction.
// ============================================================================
module call_frame_stack_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cfs_pkg::*;

   localparam int FRAME_LIMIT   = 64;
   localparam int WORD_LIMIT    = 1024;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int BURST_MAX     = 14;
   localparam int SLOT_TOP      = (1 << SLOT_BITS) - 1;

   // Highest command code the field can carry; codes above current_frame are unused.
   localparam logic [CMD_BITS-1:0] CMD_CODE_MAX = '1;

   typedef struct packed {
      logic [CMD_BITS-1:0]         command;
      logic [SLOT_BITS-1:0]        arg_count;
      logic [SLOT_BITS-1:0]        local_count;
      logic signed [WORD_BITS-1:0] ret_addr;
      logic signed [WORD_BITS-1:0] base_ptr;
      logic [SLOT_BITS-1:0]        slot_index;
      logic signed [WORD_BITS-1:0] value;
   } cmd_beat_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] read_value;
      logic [SLOT_BITS-1:0]        cur_arg_count;
      logic [SLOT_BITS-1:0]        cur_local_count;
      logic [STAT_BITS-1:0]        status;
   } reply_type;

   logic clock;
   logic reset;

   cfs_req_if req_ch ();
   cfs_rsp_if rsp_ch ();

   call_frame_stack #(
      .STACK_WORDS (WORD_LIMIT),
      .MAX_FRAMES  (FRAME_LIMIT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow of the frame stack: word store, written flags and frame records.
   logic [WORD_BITS-1:0] word_mem [WORD_LIMIT];
   bit                   word_set [WORD_LIMIT];
   logic [SLOT_BITS-1:0] rec_args [FRAME_LIMIT];
   logic [SLOT_BITS-1:0] rec_locs [FRAME_LIMIT];
   int                   rec_base [FRAME_LIMIT];
   int                   word_top;
   int                   frame_depth;

   reply_type replies_q [$];
   reply_type last_reply;
   int        fail_count;
   int        beats_sent;
   int        status_seen [4];
   int        deepest_frame;
   int        highest_top;
   bit        gaps_on;
   bit        stalls_on;
   int        stall_left;
   int        idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Word address of an argument or local slot in the top frame.
   function automatic int slot_addr(bit is_arg, int idx);
      int fa;
      int b;
      fa = int'(rec_args[frame_depth-1]);
      b  = rec_base[frame_depth-1];
      return is_arg ? b + fa - 1 - idx : b + fa + LINK_WORDS + idx;
   endfunction

   // Applies one command to the shadow stack and returns the response it causes.
   function automatic reply_type apply_frame_cmd(cmd_beat_type c);
      reply_type r;
      int        need;
      int        fa;
      int        fl;
      int        b;
      int        addr;
      r = '0;
      r.status = STAT_OK;
      if (c.command == CMD_CALL) begin
         need = int'(c.arg_count) + int'(c.local_count) + LINK_WORDS;
         if (frame_depth >= FRAME_LIMIT || need > WORD_LIMIT - word_top) begin
            r.status = STAT_FULL;
         end else begin
            b = word_top;
            rec_args[frame_depth] = c.arg_count;
            rec_locs[frame_depth] = c.local_count;
            rec_base[frame_depth] = b;
            frame_depth++;
            for (int k = 0; k < need; k++) word_set[b+k] = 1'b0;
            word_mem[b+int'(c.arg_count)]   = c.ret_addr;
            word_mem[b+int'(c.arg_count)+1] = c.base_ptr;
            word_set[b+int'(c.arg_count)]   = 1'b1;
            word_set[b+int'(c.arg_count)+1] = 1'b1;
            word_top = b + need;
         end
      end else if (c.command <= CMD_CURRENT) begin
         if (frame_depth == 0) begin
            r.status = STAT_NO_FRAME;
         end else begin
            fa = int'(rec_args[frame_depth-1]);
            fl = int'(rec_locs[frame_depth-1]);
            b  = rec_base[frame_depth-1];
            case (c.command)
               CMD_GET_LOCAL, CMD_SET_LOCAL,
               CMD_GET_ARG, CMD_SET_ARG: begin
                  if (c.command == CMD_GET_ARG || c.command == CMD_SET_ARG) begin
                     if (int'(c.slot_index) >= fa) r.status = STAT_BAD_INDEX;
                     addr = slot_addr(1'b1, int'(c.slot_index));
                  end else begin
                     if (int'(c.slot_index) >= fl) r.status = STAT_BAD_INDEX;
                     addr = slot_addr(1'b0, int'(c.slot_index));
                  end
                  if (r.status != STAT_OK) begin
                  end else if (c.command == CMD_GET_ARG || c.command == CMD_GET_LOCAL) begin
                     r.read_value = word_mem[addr];
                  end else begin
                     word_mem[addr] = c.value;
                     word_set[addr] = 1'b1;
                  end
               end
               CMD_GET_BP: r.read_value = word_mem[b+fa+1];
               CMD_GET_RA: r.read_value = word_mem[b+fa];
               CMD_RETURN: begin
                  word_top = b;
                  frame_depth--;
               end
               default: ;
            endcase
         end
      end
      if (frame_depth > 0) begin
         r.cur_arg_count   = rec_args[frame_depth-1];
         r.cur_local_count = rec_locs[frame_depth-1];
      end
      status_seen[r.status]++;
      if (frame_depth > deepest_frame) deepest_frame = frame_depth;
      if (word_top > highest_top) highest_top = word_top;
      return r;
   endfunction

   // Fully random beat; callers override the fields that matter.
   function automatic cmd_beat_type noise_beat();
      cmd_beat_type c;
      c.command     = CMD_BITS'($urandom_range(0, CMD_CODE_MAX));
      c.arg_count   = SLOT_BITS'($urandom_range(0, SLOT_TOP));
      c.local_count = SLOT_BITS'($urandom_range(0, SLOT_TOP));
      c.ret_addr    = $urandom;
      c.base_ptr    = $urandom;
      c.slot_index  = SLOT_BITS'($urandom_range(0, SLOT_TOP));
      c.value       = $urandom;
      return c;
   endfunction

   // Sends one command beat, optionally after a gap, and records its prediction.
   task automatic send_cmd(input cmd_beat_type c);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, BURST_MAX)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= c.command;
      req_ch.arg_count   <= c.arg_count;
      req_ch.local_count <= c.local_count;
      req_ch.ret_addr    <= c.ret_addr;
      req_ch.base_ptr    <= c.base_ptr;
      req_ch.slot_index  <= c.slot_index;
      req_ch.value       <= c.value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      last_reply = apply_frame_cmd(c);
      replies_q  = {replies_q, last_reply};
      beats_sent++;
   endtask

   task automatic issue(input logic [CMD_BITS-1:0] cmd, input int idx,
                        input logic [WORD_BITS-1:0] val);
      cmd_beat_type c;
      c = noise_beat();
      c.command    = cmd;
      c.slot_index = SLOT_BITS'(idx);
      c.value      = val;
      send_cmd(c);
   endtask

   task automatic issue_call(input int ac, input int lc,
                             input logic [WORD_BITS-1:0] ra,
                             input logic [WORD_BITS-1:0] bp);
      cmd_beat_type c;
      c = noise_beat();
      c.command     = CMD_CALL;
      c.arg_count   = SLOT_BITS'(ac);
      c.local_count = SLOT_BITS'(lc);
      c.ret_addr    = ra;
      c.base_ptr    = bp;
      send_cmd(c);
   endtask

   // Holds the command channel idle until every predicted response has arrived.
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (replies_q.size() != 0) @(posedge clock);
   endtask

   // Index for a set: mostly in range, sometimes past the slot count.
   function automatic int pick_set_index(int cnt);
      if (cnt > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, cnt - 1);
      return $urandom_range(cnt, SLOT_TOP);
   endfunction

   // Index for a get: a slot already written, or one out of range.
   function automatic int pick_read_index(bit is_arg);
      int cnt;
      int cand [$];
      if (frame_depth == 0) return $urandom_range(0, SLOT_TOP);
      cnt = is_arg ? int'(last_reply.cur_arg_count) : int'(last_reply.cur_local_count);
      for (int i = 0; i < cnt; i++)
         if (word_set[slot_addr(is_arg, i)]) cand = {cand, i};
      if (cand.size() > 0 && $urandom_range(0, 7) != 0)
         return cand[$urandom_range(0, cand.size() - 1)];
      return $urandom_range(cnt, SLOT_TOP);
   endfunction

   // Writes every argument and local of the top frame named by the last response.
   task automatic fill_frame();
      int na;
      int nl;
      na = int'(last_reply.cur_arg_count);
      nl = int'(last_reply.cur_local_count);
      for (int i = 0; i < na; i++) issue(CMD_SET_ARG, i, $urandom);
      for (int i = 0; i < nl; i++) issue(CMD_SET_LOCAL, i, $urandom);
   endtask

   // Every command but call against an empty stack, plus an unused command code.
   task automatic test_empty_stack();
      for (int k = CMD_GET_LOCAL; k <= CMD_CURRENT; k++)
         issue(CMD_BITS'(k), $urandom_range(0, SLOT_TOP), $urandom);
      issue(CMD_BITS'($urandom_range(CMD_CURRENT + 1, CMD_CODE_MAX)), 0, $urandom);
   endtask

   // One full-size frame with extreme words, then an empty nested frame.
   task automatic test_basic_frame();
      issue_call(SLOT_TOP, SLOT_TOP, 32'h8000_0000, 32'h7FFF_FFFF);
      issue(CMD_SET_ARG, 0, 32'h7FFF_FFFF);
      issue(CMD_SET_ARG, SLOT_TOP - 1, 32'h8000_0000);
      issue(CMD_SET_LOCAL, 0, 32'hFFFF_FFFF);
      issue(CMD_SET_LOCAL, SLOT_TOP - 1, 32'h0000_0000);
      issue(CMD_GET_ARG, 0, $urandom);
      issue(CMD_GET_ARG, SLOT_TOP - 1, $urandom);
      issue(CMD_GET_LOCAL, 0, $urandom);
      issue(CMD_GET_LOCAL, SLOT_TOP - 1, $urandom);
      issue(CMD_GET_BP, 0, $urandom);
      issue(CMD_GET_RA, 0, $urandom);
      issue(CMD_GET_ARG, SLOT_TOP, $urandom);
      issue_call(0, 0, $urandom, $urandom);
      issue(CMD_GET_LOCAL, 0, $urandom);
      issue(CMD_RETURN, 0, $urandom);
      issue(CMD_CURRENT, 0, $urandom);
      issue(CMD_RETURN, 0, $urandom);
   endtask

   // Push frames until the frame stack itself is full, then unwind past empty.
   task automatic test_frame_limit();
      for (int k = 0; k <= FRAME_LIMIT; k++)
         issue_call($urandom_range(0, 7), $urandom_range(0, 7), $urandom, $urandom);
      fill_frame();
      issue(CMD_GET_ARG, pick_read_index(1'b1), $urandom);
      for (int k = 0; k <= FRAME_LIMIT; k++) begin
         if ($urandom_range(0, 3) == 0) issue(CMD_GET_BP, 0, $urandom);
         issue(CMD_RETURN, 0, $urandom);
      end
   endtask

   // Push large frames until the word store runs out, then unwind.
   task automatic test_word_limit();
      for (int k = 0; k < FRAME_LIMIT && last_reply.status != STAT_FULL; k++)
         issue_call($urandom_range(8, SLOT_TOP), $urandom_range(8, SLOT_TOP),
                    $urandom, $urandom);
      fill_frame();
      issue(CMD_GET_LOCAL, pick_read_index(1'b0), $urandom);
      issue(CMD_GET_ARG, pick_read_index(1'b1), $urandom);
      while (frame_depth > 0) begin
         issue(CMD_GET_RA, 0, $urandom);
         issue(CMD_RETURN, 0, $urandom);
      end
   endtask

   // Mostly well-formed call, fill, access and return sequences with some noise.
   task automatic test_random_flow(input int n_items);
      int start;
      int pick;
      start = beats_sent;
      while (beats_sent - start < n_items) begin
         pick = $urandom_range(0, 99);
         if ((frame_depth == 0 && pick < 85) || pick < 12) begin
            if ($urandom_range(0, 3) == 0)
               issue_call($urandom_range(0, SLOT_TOP), $urandom_range(0, SLOT_TOP),
                          $urandom, $urandom);
            else
               issue_call($urandom_range(0, 4), $urandom_range(0, 4), $urandom, $urandom);
            if (last_reply.status == STAT_OK && $urandom_range(0, 9) < 7) fill_frame();
         end else if (pick < 22 || (frame_depth > 16 && pick < 40)) begin
            issue(CMD_RETURN, $urandom_range(0, SLOT_TOP), $urandom);
         end else if (pick < 48) begin
            if (pick[0])
               issue(CMD_SET_ARG, pick_set_index(int'(last_reply.cur_arg_count)),
                     $urandom);
            else
               issue(CMD_SET_LOCAL, pick_set_index(int'(last_reply.cur_local_count)),
                     $urandom);
         end else if (pick < 80) begin
            if (pick[0]) issue(CMD_GET_ARG, pick_read_index(1'b1), $urandom);
            else issue(CMD_GET_LOCAL, pick_read_index(1'b0), $urandom);
         end else if (pick < 90) begin
            issue(pick[0] ? CMD_GET_BP : CMD_GET_RA, $urandom_range(0, SLOT_TOP), $urandom);
         end else if (pick < 96) begin
            issue(CMD_CURRENT, $urandom_range(0, SLOT_TOP), $urandom);
         end else begin
            issue(CMD_BITS'($urandom_range(CMD_CURRENT + 1, CMD_CODE_MAX)),
                  $urandom_range(0, SLOT_TOP), $urandom);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
                              input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Response stalls come in random bursts while enabled.
   always @(posedge clock) begin
      if (reset || !stalls_on) begin
         stall_left = 0;
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, BURST_MAX);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Sample each response beat at the edge, check it once the edge has settled.
   always begin : reply_check
      reply_type got;
      reply_type want;
      bit        fired;
      @(posedge clock);
      fired = !reset && rsp_ch.valid && rsp_ch.ready;
      got.read_value      = rsp_ch.read_value;
      got.cur_arg_count   = rsp_ch.cur_arg_count;
      got.cur_local_count = rsp_ch.cur_local_count;
      got.status          = rsp_ch.status;
      @(negedge clock);
      if (fired) begin
         if (replies_q.size() == 0) begin
            $display("%0t: response beat with none expected, actual %h", $time, got);
            fail_count++;
         end else begin
            want = replies_q.pop_front();
            check_field("read_value", want.read_value, got.read_value);
            check_field("cur_arg_count", WORD_BITS'(want.cur_arg_count),
                        WORD_BITS'(got.cur_arg_count));
            check_field("cur_local_count", WORD_BITS'(want.cur_local_count),
                        WORD_BITS'(got.cur_local_count));
            check_field("status", WORD_BITS'(want.status), WORD_BITS'(got.status));
         end
      end
   end

   // Ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("call_frame_stack_test failed");
            $finish;
         end
      end
   end

   initial begin
      fail_count    = 0;
      beats_sent    = 0;
      word_top      = 0;
      frame_depth   = 0;
      deepest_frame = 0;
      highest_top   = 0;
      idle_cycles   = 0;
      last_reply    = '0;
      gaps_on       = 1'b0;
      stalls_on     = 1'b0;
      for (int s = 0; s < 4; s++) status_seen[s] = 0;
      for (int a = 0; a < WORD_LIMIT; a++) word_set[a] = 1'b0;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_CALL;
      req_ch.arg_count   <= '0;
      req_ch.local_count <= '0;
      req_ch.ret_addr    <= '0;
      req_ch.base_ptr    <= '0;
      req_ch.slot_index  <= '0;
      req_ch.value       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_basic_frame();
      test_frame_limit();
      test_word_limit();
      test_random_flow(40);
      drain_replies();
      test_random_flow(40);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_random_flow(30);

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands: %0d ok, %0d bad index, %0d no frame, %0d full.",
               beats_sent, status_seen[STAT_OK], status_seen[STAT_BAD_INDEX],
               status_seen[STAT_NO_FRAME], status_seen[STAT_FULL]);
      $display("Deepest frame stack %0d, highest word top %0d.", deepest_frame, highest_top);
      if (fail_count == 0) begin
         $display("call_frame_stack_test passed");
      end else begin
         $display("call_frame_stack_test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/cfs_pkg.sv
rtl/cfs_req_if.sv
rtl/cfs_rsp_if.sv
rtl/cfs_ram.sv
rtl/call_frame_stack.sv
dv/call_frame_stack_test.sv
